### rtl/core/hpt_pkg.sv
// shared types, constants and helpers for the hall period tachometer
package hpt_pkg;

  localparam int unsigned CFG_W  = 32;
  localparam int unsigned TPM_W  = 32;
  localparam int unsigned CIRC_W = 20;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned PROD_W = TPM_W + CIRC_W;
  localparam int unsigned IDX_W  = 1;
  localparam int unsigned MM_W   = 16;

  localparam logic [TPM_W-1:0]  TPM_RESET  = 32'd13818750;
  localparam logic [CIRC_W-1:0] CIRC_RESET = 20'd111658;
  localparam logic [MM_W-1:0]   UM_MM_MIN  = 16'd60000;

  localparam logic [IDX_W-1:0] REG_TPM  = 1'b0;
  localparam logic [IDX_W-1:0] REG_CIRC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RPM,
    ST_SPD,
    ST_OUT
  } hpt_state_t;

  typedef struct packed {
    logic emit;
    logic sat;
  } hpt_cnt_evt_t;

  function automatic logic [OUT_W-1:0] sat32(input logic [PROD_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (|v[PROD_W-1:OUT_W]) begin
      r = '1;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/hpt_if.sv
// valid/ready channel interfaces for sensor samples and results
interface hpt_in_if;
  logic valid;
  logic ready;
  logic hall_low;

  modport source (output valid, output hall_low, input ready);
  modport sink (input valid, input hall_low, output ready);
endinterface

interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] period_ticks;
  logic [31:0] rpm_x16;
  logic [31:0] speed_mm_per_s;
  logic        saturated;

  modport source (output valid, output period_ticks, output rpm_x16,
                  output speed_mm_per_s, output saturated, input ready);
  modport sink (input valid, input period_ticks, input rpm_x16,
                input speed_mm_per_s, input saturated, output ready);
endinterface

### rtl/core/hall_period_tachometer_unit.sv
// Hall period tachometer top level: one input transfer per timer tick with the
// active-low hall level. A tick with no new magnet pass is absorbed and the block stays idle.
// On the first tick of a magnet pass the block captures the period and runs a
// 20x32 multiply then two 52-step passes of one shared restoring divider
// (rpm, then the product over 60000 times the period) and takes no new input
// until its result is loaded into the output register; a zero period skips the
// divides. The result sits in an output register until its transfer; a further
// result waits for that transfer and holds off the input.
module hall_period_tachometer_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hpt_pkg::IDX_W-1:0]            cfg_index,
  input  logic [hpt_pkg::CFG_W-1:0]            cfg_wdata,
  hpt_in_if.sink                               in_ch,
  hpt_out_if.source                            out_ch
);

  localparam int unsigned PW = hpt_pkg::PROD_W;
  localparam int unsigned OW = hpt_pkg::OUT_W;
  localparam int unsigned DW = COUNT_WIDTH + hpt_pkg::MM_W;

  hpt_pkg::hpt_state_t state_r, state_nxt;

  logic [hpt_pkg::TPM_W-1:0]  tpm_r;
  logic [hpt_pkg::CIRC_W-1:0] circ_r;

  logic [COUNT_WIDTH-1:0] p_r;
  logic                   sat_r;
  logic [PW-1:0]          prod_r;
  logic [OW-1:0]          rpm_r;
  logic [OW-1:0]          spd_r;

  logic [OW-1:0] out_period_r, out_rpm_r, out_spd_r;
  logic          out_sat_r;
  logic          out_valid_r, out_valid_nxt;

  hpt_pkg::hpt_cnt_evt_t  evt;
  logic [COUNT_WIDTH-1:0] cnt_period;
  logic                   in_xfer;

  logic                   div_start;
  logic [PW-1:0]          div_dividend;
  logic [DW-1:0]          div_divisor;
  logic                   div_done;
  logic [PW-1:0]          div_quo;

  logic capture, capture_zero, load_prod, load_rpm, load_spd, load_out;

  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state_r == hpt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r  <= hpt_pkg::TPM_RESET;
      circ_r <= hpt_pkg::CIRC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hpt_pkg::REG_TPM:  tpm_r  <= cfg_wdata[hpt_pkg::TPM_W-1:0];
        hpt_pkg::REG_CIRC: circ_r <= cfg_wdata[hpt_pkg::CIRC_W-1:0];
        default: ;
      endcase
    end
  end

  hpt_tick_counter #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counter (
    .clk      (clk),
    .rst_n    (rst_n),
    .sample_en(in_xfer),
    .hall_low (in_ch.hall_low),
    .evt      (evt),
    .period   (cnt_period)
  );

  hpt_div #(
    .DVD_W(PW),
    .DVS_W(DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_dividend  = PW'({tpm_r, 4'b0000});
    div_divisor   = DW'(p_r);
    capture       = 1'b0;
    capture_zero  = 1'b0;
    load_prod     = 1'b0;
    load_rpm      = 1'b0;
    load_spd      = 1'b0;
    load_out      = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      hpt_pkg::ST_IDLE: begin
        if (in_xfer && evt.emit) begin
          capture = 1'b1;
          if (cnt_period == '0) begin
            capture_zero = 1'b1;
            state_nxt    = hpt_pkg::ST_OUT;
          end else begin
            state_nxt = hpt_pkg::ST_MUL;
          end
        end
      end
      hpt_pkg::ST_MUL: begin
        load_prod = 1'b1;
        div_start = 1'b1;
        state_nxt = hpt_pkg::ST_RPM;
      end
      hpt_pkg::ST_RPM: begin
        div_dividend = prod_r;
        div_divisor  = DW'(p_r) * DW'(hpt_pkg::UM_MM_MIN);
        if (div_done) begin
          load_rpm  = 1'b1;
          div_start = 1'b1;
          state_nxt = hpt_pkg::ST_SPD;
        end
      end
      hpt_pkg::ST_SPD: begin
        if (div_done) begin
          load_spd  = 1'b1;
          state_nxt = hpt_pkg::ST_OUT;
        end
      end
      hpt_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = hpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      p_r   <= cnt_period;
      sat_r <= evt.sat;
    end
    if (capture_zero) begin
      rpm_r <= '0;
      spd_r <= '0;
    end
    if (load_prod) begin
      prod_r <= PW'(circ_r) * PW'(tpm_r);
    end
    if (load_rpm) begin
      rpm_r <= hpt_pkg::sat32(div_quo);
    end
    if (load_spd) begin
      spd_r <= hpt_pkg::sat32(div_quo);
    end
    if (load_out) begin
      out_period_r <= hpt_pkg::sat32(PW'(p_r));
      out_rpm_r    <= rpm_r;
      out_spd_r    <= spd_r;
      out_sat_r    <= sat_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.period_ticks   = out_period_r;
  assign out_ch.rpm_x16        = out_rpm_r;
  assign out_ch.speed_mm_per_s = out_spd_r;
  assign out_ch.saturated      = out_sat_r;

`ifndef SYNTHESIS
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == hpt_pkg::ST_RPM || state_r == hpt_pkg::ST_SPD))
    else $error("divider finished outside a divide step");

  a_pass_starts_math: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && evt.emit && cnt_period != '0) |=> (state_r == hpt_pkg::ST_MUL))
    else $error("magnet pass with nonzero period did not start the arithmetic");

  a_zero_period_zero_rates: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_period_r == '0) |-> (out_rpm_r == '0 && out_spd_r == '0))
    else $error("zero period gave nonzero rpm or speed");

  a_out_held_until_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hpt_pkg::ST_OUT && out_valid_r && !out_ch.ready) |=>
      (state_r == hpt_pkg::ST_OUT && out_valid_r))
    else $error("pending result overwritten before its transfer");
`endif

endmodule

### rtl/core/hpt_tick_counter.sv
// saturating tick counter with magnet edge detection
module hpt_tick_counter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     sample_en,
  input  logic                     hall_low,
  output hpt_pkg::hpt_cnt_evt_t    evt,
  output logic [COUNT_WIDTH-1:0]   period
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   sat_r, sat_nxt;
  logic                   was_r, was_nxt;

  always_comb begin
    count_nxt = count_r;
    sat_nxt   = sat_r;
    was_nxt   = was_r;
    if (sample_en) begin
      if (hall_low) begin
        count_nxt = '0;
        sat_nxt   = 1'b0;
        was_nxt   = 1'b1;
      end else begin
        if (count_r != CNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
        if (count_nxt == CNT_MAX) begin
          sat_nxt = 1'b1;
        end
        was_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sat_r   <= 1'b0;
      was_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sat_r   <= sat_nxt;
      was_r   <= was_nxt;
    end
  end

  assign evt.emit = hall_low & ~was_r;
  assign evt.sat  = sat_r;
  assign period   = count_r;

endmodule

### rtl/core/hpt_div.sv
// restoring divider, one quotient bit per cycle
module hpt_div #(
  parameter int unsigned DVD_W = 52,
  parameter int unsigned DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= LAST_STEP;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### bench/hall_period_tachometer_unit_tb.sv
// self-checking bench for the hall period tachometer unit
module hall_period_tachometer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_TICKS = 170;
  localparam int unsigned PLAN_ROWS = 21;

  typedef struct packed {
    logic [31:0] period_ticks;
    logic [31:0] rpm_x16;
    logic [31:0] speed_mm_per_s;
    logic        saturated;
  } tach_reading_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKED} rx_mode_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [hpt_pkg::IDX_W-1:0] reg_sel;
    logic                      hall;
    logic [31:0]               arg;
    logic                      typed;
    tach_reading_t             want;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0}},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd2, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b0, 32'd1, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b1,
      '{32'd1, 32'd221100000, 32'd25716233, 1'b0}},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b0, 32'd2, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b0, 32'd40, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b0, '0},
    '{ROW_CFG, hpt_pkg::REG_TPM, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CFG, hpt_pkg::REG_CIRC, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b0, 32'd1, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b1,
      '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b0, 32'd3, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b0, '0},
    '{ROW_CFG, hpt_pkg::REG_TPM, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b0, 32'd5, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b1, '{32'd5, 32'd0, 32'd0, 1'b0}},
    '{ROW_CFG, hpt_pkg::REG_TPM, 1'b0, 32'd1, 1'b0, '0},
    '{ROW_CFG, hpt_pkg::REG_CIRC, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b0, 32'd1, 1'b0, '0},
    '{ROW_TICK, hpt_pkg::REG_TPM, 1'b1, 32'd1, 1'b1, '{32'd1, 32'd16, 32'd0, 1'b0}}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [hpt_pkg::IDX_W-1:0] cfg_index;
  logic [hpt_pkg::CFG_W-1:0] cfg_wdata;

  hpt_in_if  in_ch ();
  hpt_out_if out_ch ();

  hall_period_tachometer_unit #(
    .COUNT_WIDTH (CNT_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [31:0]                tpm_setting;
  logic [hpt_pkg::CIRC_W-1:0] circ_setting;
  logic                       magnet_seen;
  logic [CNT_W-1:0]           ticks_since_pass;
  logic                       count_pinned;

  tach_reading_t readings_due [$];
  int unsigned   error_count = 0;
  int unsigned   stall_run = 0;
  int unsigned   holds_asked = 0;
  int unsigned   holds_done = 0;
  int unsigned   burst_left = 0;
  bit            steady_sender = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic bit tach_tick(input logic hall, output tach_reading_t r);
    logic [63:0] span;
    logic [63:0] surface;
    bit          emit;
    emit = 1'b0;
    r = '0;
    if (hall) begin
      if (!magnet_seen) begin
        span = 64'(ticks_since_pass);
        r.period_ticks = clip32(span);
        if (span != 0) begin
          r.rpm_x16 = clip32((64'(tpm_setting) * 64'd16) / span);
          surface = (64'(circ_setting) * 64'(tpm_setting)) / 64'(hpt_pkg::UM_MM_MIN);
          r.speed_mm_per_s = clip32(surface / span);
        end
        r.saturated = count_pinned;
        emit = 1'b1;
      end
      ticks_since_pass = '0;
      count_pinned = 1'b0;
      magnet_seen = 1'b1;
    end else begin
      if (ticks_since_pass != CNT_MAX) ticks_since_pass++;
      if (ticks_since_pass == CNT_MAX) count_pinned = 1'b1;
      magnet_seen = 1'b0;
    end
    return emit;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic set_register(input logic [hpt_pkg::IDX_W-1:0] idx,
                              input logic [hpt_pkg::CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hpt_pkg::REG_TPM:  tpm_setting = data;
      hpt_pkg::REG_CIRC: circ_setting = data[hpt_pkg::CIRC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(input logic hall, input logic typed, input tach_reading_t want);
    tach_reading_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady_sender && $urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.hall_low <= hall;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (tach_tick(hall, r)) readings_due.push_back(typed ? want : r);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int unsigned seg;
    rx_mode_t    mode;
    out_ch.ready <= 1'b0;
    forever begin
      seg = $urandom_range(20, 300);
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat (seg) begin
        @(posedge clk);
        if (holds_done != holds_asked) begin
          holds_done++;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= logic'($urandom_range(0, 1));
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    tach_reading_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_run = 0;
    end else begin
      stall_run++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (readings_due.size() == 0) begin
        flag_mismatch("reading with none due, period", out_ch.period_ticks, 32'd0);
      end else begin
        want = readings_due.pop_front();
        if (out_ch.period_ticks !== want.period_ticks)
          flag_mismatch("period_ticks", out_ch.period_ticks, want.period_ticks);
        if (out_ch.rpm_x16 !== want.rpm_x16)
          flag_mismatch("rpm_x16", out_ch.rpm_x16, want.rpm_x16);
        if (out_ch.speed_mm_per_s !== want.speed_mm_per_s)
          flag_mismatch("speed_mm_per_s", out_ch.speed_mm_per_s, want.speed_mm_per_s);
        if (out_ch.saturated !== want.saturated)
          flag_mismatch("saturated", 32'(out_ch.saturated), 32'(want.saturated));
      end
    end
  end

  initial begin
    while (stall_run < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned run;
    int unsigned sent;
    in_ch.valid <= 1'b0;
    in_ch.hall_low <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= hpt_pkg::REG_TPM;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    tpm_setting = hpt_pkg::TPM_RESET;
    circ_setting = hpt_pkg::CIRC_RESET;
    magnet_seen = 1'b0;
    ticks_since_pass = '0;
    count_pinned = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        quiesce();
        set_register(PLAN[i].reg_sel, PLAN[i].arg);
      end else begin
        repeat (PLAN[i].arg) send_tick(PLAN[i].hall, PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph)
        0: begin
          set_register(hpt_pkg::REG_TPM, 32'hFFFF_FFFF);
          set_register(hpt_pkg::REG_CIRC, 32'd1000000);
        end
        1: begin
          set_register(hpt_pkg::REG_TPM, 32'd1);
          set_register(hpt_pkg::REG_CIRC, 32'd1);
        end
        2: begin
          set_register(hpt_pkg::REG_TPM, $urandom());
          set_register(hpt_pkg::REG_CIRC, $urandom_range(1, 1000000));
        end
        3: begin
          set_register(hpt_pkg::REG_TPM, $urandom_range(1, 5000));
          set_register(hpt_pkg::REG_CIRC, $urandom());
        end
        4: begin
          set_register(hpt_pkg::REG_TPM, hpt_pkg::TPM_RESET);
          set_register(hpt_pkg::REG_CIRC, 32'(hpt_pkg::CIRC_RESET));
        end
        default: begin
          set_register(hpt_pkg::REG_TPM, $urandom());
          set_register(hpt_pkg::REG_CIRC, $urandom());
        end
      endcase
      steady_sender = (ph == 4);
      // long receiver hold-off while ticks keep coming
      if (ph == 2) holds_asked++;
      sent = 0;
      while (sent < PHASE_TICKS) begin
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
          run = $urandom_range(1, 8);
          repeat (run) send_tick(logic'($urandom_range(0, 1)), 1'b0, '0);
          sent += run;
        end else begin
          if (pick < 6) run = $urandom_range(1, 12);
          else if (pick == 6) run = $urandom_range(13, 100);
          else if (pick == 7) run = 0;
          else run = $urandom_range(1, 3);
          repeat (run) send_tick(1'b0, 1'b0, '0);
          sent += run;
          run = $urandom_range(1, 4);
          repeat (run) send_tick(1'b1, 1'b0, '0);
          sent += run;
        end
      end
    end

    quiesce();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
